/* rtl/core/rbec_pkg.sv */
// ============================================================================
// rbec_pkg - shared types, constants and helpers for the RTC epoch converter
// Calendar constants, reciprocal multipliers for the constant divisions,
// BCD helpers and the word structs passed between the pipeline modules.
// ============================================================================
package rbec_pkg;

    // Register stages of the longer (epoch to BCD) pipeline; the other path
    // is padded to the same depth so words leave in order.
    localparam int unsigned DEC_STAGES = 9;
    localparam int unsigned ENC_STAGES = 3;
    localparam int unsigned ENC_PAD    = DEC_STAGES - ENC_STAGES;

    // Conversion direction
    localparam logic MODE_TO_EPOCH = 1'b0;
    localparam logic MODE_TO_BCD   = 1'b1;

    // Time constants
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned YEAR_MIN_OK   = 25;

    // Day numbers since 1970-01-01 of some anchor dates
    localparam int unsigned DAY_MAR_1999 = 10651;
    localparam int unsigned DAY_JAN_2000 = 10957;
    localparam int unsigned DAY_MAR_2000 = 11017;
    localparam int unsigned DAY_JAN_2100 = 47482;

    // Weekday offset: day 0 was a Thursday
    localparam int unsigned WEEKDAY_OFS = 4;

    // March-based month index of January
    localparam logic [3:0] MP_JAN = 4'd10;

    // Reciprocal multipliers: floor(x / d) = (x * MUL) >> SHIFT
    localparam logic [25:0] DIV675_MUL = 26'd50903316; // floor, one fix-up step
    localparam logic [23:0] DIV365_MUL = 24'd11767034; // exact for x < 2^16
    localparam logic [20:0] DIV225_MUL = 21'd1193047;  // exact for x < 10025
    localparam logic [16:0] DIV15_MUL  = 17'd69906;    // exact for x < 4993
    localparam logic [29:0] DIV7_MUL   = 30'd613566757; // exact for x < 2^17

    // Register bytes of one to-epoch word
    typedef struct packed {
        logic [7:0] seconds_reg;
        logic [7:0] minutes_reg;
        logic [7:0] hours_reg;
        logic [7:0] days_reg;
        logic [7:0] months_reg;
        logic [7:0] years_reg;
    } t_rtc_regs;

    // Result of the to-epoch path
    typedef struct packed {
        logic        valid;
        logic [31:0] epoch;
        logic        clock_valid;
    } t_enc_res;

    // Result of the to-BCD path
    typedef struct packed {
        logic       valid;
        logic [6:0] seconds_bcd;
        logic [6:0] minutes_bcd;
        logic [5:0] hours_bcd;
        logic [5:0] day_bcd;
        logic [2:0] weekday;
        logic [4:0] month_bcd;
        logic [7:0] year_bcd;
        logic       range_error;
    } t_dec_res;

    // Two BCD digits to binary, digits above nine weighted as they are
    function automatic logic [7:0] bcd_dec(input logic [7:0] b);
        return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
    endfunction

    // Binary below 100 to two BCD digits; tens by multiply with 205/2048
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  tens;
        logic [6:0]  ones;
        p    = 15'(v) * 15'd205;
        tens = p[14:11];
        ones = v - 7'(tens) * 7'd10;
        return {tens, ones[3:0]};
    endfunction

    // (153 * mp + 2) / 5: day of the March-based year where month mp starts
    function automatic logic [9:0] mar_doy(input logic [4:0] mp);
        logic [9:0] d;
        case (mp)
            5'd0:    d = 10'd0;
            5'd1:    d = 10'd31;
            5'd2:    d = 10'd61;
            5'd3:    d = 10'd92;
            5'd4:    d = 10'd122;
            5'd5:    d = 10'd153;
            5'd6:    d = 10'd184;
            5'd7:    d = 10'd214;
            5'd8:    d = 10'd245;
            5'd9:    d = 10'd275;
            5'd10:   d = 10'd306;
            5'd11:   d = 10'd337;
            5'd12:   d = 10'd367;
            5'd13:   d = 10'd398;
            5'd14:   d = 10'd428;
            5'd15:   d = 10'd459;
            5'd16:   d = 10'd490;
            5'd17:   d = 10'd520;
            5'd18:   d = 10'd551;
            5'd19:   d = 10'd581;
            5'd20:   d = 10'd612;
            5'd21:   d = 10'd643;
            5'd22:   d = 10'd673;
            default: d = 10'd0;
        endcase
        return d;
    endfunction

endpackage

/* rtl/core/rbec_enc.sv */
// ============================================================================
// rbec_enc - RTC register bytes to epoch seconds
// Three compute stages (BCD decode, day count, scale to seconds), then a
// delay line so the path matches the depth of the to-BCD pipeline.
// ============================================================================
module rbec_enc
    import rbec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_rtc_regs i_regs,
    output t_enc_res  o_res
);

    // ---------------- valid shift line, stages 1 .. DEC_STAGES-1 ----------
    logic [DEC_STAGES-2:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEC_STAGES-3:0], i_valid};
        end
    end

    // ---------------- stage 1: decode BCD, March-based month --------------
    logic [6:0]        w1_sec;
    logic [6:0]        w1_min;
    logic [5:0]        w1_hr;
    logic [5:0]        w1_day;
    logic [4:0]        w1_mon;
    logic [7:0]        w1_yr;
    logic              w1_early;
    logic [4:0]        w1_mp;
    logic signed [8:0] w1_yy;
    logic signed [10:0] w1_doy;
    logic              w1_cv;

    assign w1_sec   = 7'(bcd_dec({1'b0, i_regs.seconds_reg[6:0]}));
    assign w1_min   = 7'(bcd_dec({1'b0, i_regs.minutes_reg[6:0]}));
    assign w1_hr    = 6'(bcd_dec({2'b0, i_regs.hours_reg[5:0]}));
    assign w1_day   = 6'(bcd_dec({2'b0, i_regs.days_reg[5:0]}));
    assign w1_mon   = 5'(bcd_dec({3'b0, i_regs.months_reg[4:0]}));
    assign w1_yr    = bcd_dec(i_regs.years_reg);
    // Jan/Feb (and month 0) count in the previous March-based year
    assign w1_early = (w1_mon <= 5'd2);
    assign w1_mp    = w1_early ? (w1_mon + 5'd9) : (w1_mon - 5'd3);
    assign w1_yy    = signed'({1'b0, w1_yr}) - signed'({8'b0, w1_early});
    assign w1_doy   = signed'({1'b0, mar_doy(w1_mp)}) + signed'({5'b0, w1_day}) - 11'sd1;
    assign w1_cv    = ~i_regs.seconds_reg[7] & (w1_yr >= 8'(YEAR_MIN_OK));

    logic signed [8:0]  r1_yy;
    logic signed [10:0] r1_doy;
    logic [6:0]         r1_sec;
    logic [6:0]         r1_min;
    logic [5:0]         r1_hr;
    logic               r1_cv;

    always_ff @(posedge i_clk) begin
        r1_yy  <= w1_yy;
        r1_doy <= w1_doy;
        r1_sec <= w1_sec;
        r1_min <= w1_min;
        r1_hr  <= w1_hr;
        r1_cv  <= w1_cv;
    end

    // ---------------- stage 2: days since 1970, seconds of day ------------
    // Years counted from March 2000; year -1 (March 1999) is a leap year.
    logic [18:0] w2_days;
    logic [17:0] w2_tod;

    assign w2_days = 19'(DAY_MAR_2000)
                   + 19'(r1_yy) * 19'(DAYS_PER_YEAR)
                   + 19'(r1_yy >>> 2)
                   - 19'(r1_yy >= 9'sd100)
                   + 19'(r1_doy);
    assign w2_tod  = 18'(r1_hr) * 18'(SECS_PER_HOUR)
                   + 18'(r1_min) * 18'(SECS_PER_MIN)
                   + 18'(r1_sec);

    logic [16:0] r2_days;
    logic [17:0] r2_tod;
    logic        r2_cv;

    always_ff @(posedge i_clk) begin
        r2_days <= w2_days[16:0];
        r2_tod  <= w2_tod;
        r2_cv   <= r1_cv;
    end

    // ---------------- stage 3: scale to seconds, wraps at 32 bits ---------
    logic [31:0] w3_epoch;
    assign w3_epoch = 32'(r2_days) * 32'(SECS_PER_DAY) + 32'(r2_tod);

    logic [31:0] r3_epoch;
    logic        r3_cv;

    always_ff @(posedge i_clk) begin
        r3_epoch <= w3_epoch;
        r3_cv    <= r2_cv;
    end

    // ---------------- delay line to match the to-BCD depth ----------------
    logic [31:0] r_dly_epoch [ENC_PAD-1];
    logic [31:0] w_dly_epoch;
    logic [ENC_PAD-2:0] r_dly_cvb;

    always_ff @(posedge i_clk) begin
        r_dly_epoch[0] <= r3_epoch;
        r_dly_cvb[0]   <= r3_cv;
        for (int i = 1; i < ENC_PAD - 1; i++) begin
            r_dly_epoch[i] <= r_dly_epoch[i-1];
            r_dly_cvb[i]   <= r_dly_cvb[i-1];
        end
    end

    assign w_dly_epoch = r_dly_epoch[ENC_PAD-2];

    // ---------------- last stage: result word -----------------------------
    t_enc_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res.valid       <= r_vld[DEC_STAGES-2];
            r_res.epoch       <= w_dly_epoch;
            r_res.clock_valid <= r_dly_cvb[ENC_PAD-2];
        end
    end

    assign o_res = r_res;

endmodule

/* rtl/core/rbec_dec.sv */
// ============================================================================
// rbec_dec - epoch seconds to RTC BCD fields
// Nine stages: split into days and seconds of day, civil date from the
// day count, weekday, hours/minutes/seconds, then BCD and range check.
// ============================================================================
module rbec_dec
    import rbec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_epoch,
    output t_dec_res    o_res
);

    // ---------------- valid shift line, stages 1 .. DEC_STAGES-1 ----------
    logic [DEC_STAGES-2:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEC_STAGES-3:0], i_valid};
        end
    end

    // ---------------- stage 1: day estimate, (e >> 7) / 675 ---------------
    // Floor reciprocal: estimate is exact or one low.
    logic [50:0] w1_prod;
    assign w1_prod = 51'(i_epoch[31:7]) * 51'(DIV675_MUL);

    logic [15:0] r1_q;
    logic [31:0] r1_e;

    always_ff @(posedge i_clk) begin
        r1_q <= w1_prod[50:35];
        r1_e <= i_epoch;
    end

    // ---------------- stage 2: remainder of the estimate ------------------
    logic [32:0] w2_prod;
    logic [32:0] w2_rem;
    assign w2_prod = 33'(r1_q) * 33'(SECS_PER_DAY);
    assign w2_rem  = {1'b0, r1_e} - w2_prod;

    logic [15:0] r2_q;
    logic [17:0] r2_rem;

    always_ff @(posedge i_clk) begin
        r2_q   <= r1_q;
        r2_rem <= w2_rem[17:0];
    end

    // ---------------- stage 3: fix-up, days and seconds of day ------------
    logic        w3_fix;
    logic [17:0] w3_sub;
    assign w3_fix = (r2_rem >= 18'(SECS_PER_DAY));
    assign w3_sub = r2_rem - 18'(SECS_PER_DAY);

    logic [15:0] r3_days;
    logic [16:0] r3_sod;

    always_ff @(posedge i_clk) begin
        r3_days <= r2_q + 16'(w3_fix);
        r3_sod  <= w3_fix ? w3_sub[16:0] : r2_rem[16:0];
    end

    // ---------------- stage 4: range, day of era, hour, weekday quotient --
    // Jan/Feb 2000 fall in the March 1999 year; that one is counted apart.
    logic        w4_ok;
    logic        w4_neg;
    logic [15:0] w4_doe;
    logic [16:0] w4_wk;
    logic [46:0] w4_wprod;
    logic [33:0] w4_hprod;

    assign w4_ok    = (r3_days >= 16'(DAY_JAN_2000)) && (r3_days < 16'(DAY_JAN_2100));
    assign w4_neg   = (r3_days < 16'(DAY_MAR_2000));
    assign w4_doe   = w4_neg ? (r3_days - 16'(DAY_MAR_1999)) : (r3_days - 16'(DAY_MAR_2000));
    assign w4_wk    = 17'(r3_days) + 17'(WEEKDAY_OFS);
    assign w4_wprod = 47'(w4_wk) * 47'(DIV7_MUL);
    assign w4_hprod = 34'(r3_sod[16:4]) * 34'(DIV225_MUL);

    logic        r4_ok;
    logic        r4_neg;
    logic [15:0] r4_doe;
    logic [16:0] r4_wk;
    logic [12:0] r4_q7;
    logic [16:0] r4_sod;
    logic [4:0]  r4_hr;

    always_ff @(posedge i_clk) begin
        r4_ok  <= w4_ok;
        r4_neg <= w4_neg;
        r4_doe <= w4_doe;
        r4_wk  <= w4_wk;
        r4_q7  <= w4_wprod[44:32];
        r4_sod <= r3_sod;
        r4_hr  <= w4_hprod[32:28];
    end

    // ---------------- stage 5: doe / 1460, weekday, seconds of hour -------
    logic [37:0] w5_qprod;
    logic [16:0] w5_q7x7;
    logic [16:0] w5_wd;
    logic [16:0] w5_hsec;
    logic [16:0] w5_rem;

    assign w5_qprod = 38'(r4_doe[15:2]) * 38'(DIV365_MUL);
    assign w5_q7x7  = (17'(r4_q7) << 3) - 17'(r4_q7);
    assign w5_wd    = r4_wk - w5_q7x7;
    assign w5_hsec  = 17'(r4_hr) * 17'(SECS_PER_HOUR);
    assign w5_rem   = r4_sod - w5_hsec;

    logic        r5_ok;
    logic        r5_neg;
    logic [15:0] r5_doe;
    logic [4:0]  r5_q1;
    logic [2:0]  r5_wd;
    logic [11:0] r5_rem;
    logic [4:0]  r5_hr;

    always_ff @(posedge i_clk) begin
        r5_ok  <= r4_ok;
        r5_neg <= r4_neg;
        r5_doe <= r4_doe;
        r5_q1  <= w5_qprod[36:32];
        r5_wd  <= w5_wd[2:0];
        r5_rem <= w5_rem[11:0];
        r5_hr  <= r4_hr;
    end

    // ---------------- stage 6: year of era, minutes -----------------------
    logic [15:0] w6_x;
    logic [39:0] w6_yprod;
    logic [26:0] w6_mprod;

    assign w6_x     = r5_doe - 16'(r5_q1);
    assign w6_yprod = 40'(w6_x) * 40'(DIV365_MUL);
    assign w6_mprod = 27'(r5_rem[11:2]) * 27'(DIV15_MUL);

    logic        r6_ok;
    logic        r6_neg;
    logic [15:0] r6_doe;
    logic [6:0]  r6_yoe;
    logic [2:0]  r6_wd;
    logic [11:0] r6_rem;
    logic [4:0]  r6_hr;
    logic [5:0]  r6_min;

    always_ff @(posedge i_clk) begin
        r6_ok  <= r5_ok;
        r6_neg <= r5_neg;
        r6_doe <= r5_doe;
        r6_yoe <= w6_yprod[38:32];
        r6_wd  <= r5_wd;
        r6_rem <= r5_rem;
        r6_hr  <= r5_hr;
        r6_min <= w6_mprod[25:20];
    end

    // ---------------- stage 7: day of year, seconds -----------------------
    logic [15:0] w7_doy;
    logic [11:0] w7_sec;

    assign w7_doy = r6_doe - 16'(r6_yoe) * 16'(DAYS_PER_YEAR) - 16'(r6_yoe[6:2]);
    assign w7_sec = r6_rem - 12'(r6_min) * 12'(SECS_PER_MIN);

    logic        r7_ok;
    logic        r7_neg;
    logic [8:0]  r7_doy;
    logic [6:0]  r7_yoe;
    logic [2:0]  r7_wd;
    logic [4:0]  r7_hr;
    logic [5:0]  r7_min;
    logic [5:0]  r7_sec;

    always_ff @(posedge i_clk) begin
        r7_ok  <= r6_ok;
        r7_neg <= r6_neg;
        r7_doy <= r6_neg ? r6_doe[8:0] : w7_doy[8:0];
        r7_yoe <= r6_yoe;
        r7_wd  <= r6_wd;
        r7_hr  <= r6_hr;
        r7_min <= r6_min;
        r7_sec <= w7_sec[5:0];
    end

    // ---------------- stage 8: month, day of month, year ------------------
    logic [3:0] w8_mp;
    logic [9:0] w8_dom;
    logic [3:0] w8_month;
    logic [6:0] w8_year;

    // Month index: count the month starts at or below the day of year
    always_comb begin
        w8_mp = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if ({1'b0, r7_doy} >= mar_doy(5'(k))) begin
                w8_mp = w8_mp + 4'd1;
            end
        end
    end

    assign w8_dom   = {1'b0, r7_doy} - mar_doy({1'b0, w8_mp}) + 10'd1;
    assign w8_month = (w8_mp < MP_JAN) ? (w8_mp + 4'd3) : (w8_mp - 4'd9);
    assign w8_year  = r7_neg ? 7'd0 : (r7_yoe + 7'(w8_mp >= MP_JAN));

    logic       r8_ok;
    logic [4:0] r8_day;
    logic [3:0] r8_month;
    logic [6:0] r8_year;
    logic [2:0] r8_wd;
    logic [4:0] r8_hr;
    logic [5:0] r8_min;
    logic [5:0] r8_sec;

    always_ff @(posedge i_clk) begin
        r8_ok    <= r7_ok;
        r8_day   <= w8_dom[4:0];
        r8_month <= w8_month;
        r8_year  <= w8_year;
        r8_wd    <= r7_wd;
        r8_hr    <= r7_hr;
        r8_min   <= r7_min;
        r8_sec   <= r7_sec;
    end

    // ---------------- stage 9: BCD, zero fields when out of range ---------
    logic [7:0] w9_sec;
    logic [7:0] w9_min;
    logic [7:0] w9_hr;
    logic [7:0] w9_day;
    logic [7:0] w9_mon;
    logic [7:0] w9_yr;

    assign w9_sec = to_bcd(7'(r8_sec));
    assign w9_min = to_bcd(7'(r8_min));
    assign w9_hr  = to_bcd(7'(r8_hr));
    assign w9_day = to_bcd(7'(r8_day));
    assign w9_mon = to_bcd(7'(r8_month));
    assign w9_yr  = to_bcd(r8_year);

    t_dec_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res.valid       <= r_vld[DEC_STAGES-2];
            r_res.seconds_bcd <= r8_ok ? w9_sec[6:0] : 7'd0;
            r_res.minutes_bcd <= r8_ok ? w9_min[6:0] : 7'd0;
            r_res.hours_bcd   <= r8_ok ? w9_hr[5:0]  : 6'd0;
            r_res.day_bcd     <= r8_ok ? w9_day[5:0] : 6'd0;
            r_res.weekday     <= r8_ok ? r8_wd       : 3'd0;
            r_res.month_bcd   <= r8_ok ? w9_mon[4:0] : 5'd0;
            r_res.year_bcd    <= r8_ok ? w9_yr       : 8'd0;
            r_res.range_error <= ~r8_ok;
        end
    end

    assign o_res = r_res;

endmodule

/* rtl/core/rtc_bcd_epoch_converter_top.sv */
// ============================================================================
// rtc_bcd_epoch_converter_top - RTC BCD registers <-> Unix epoch seconds
//
//  channel   handshake           payload
//  --------  ------------------  ------------------------------------------
//  command   start / busy        i_mode, i_*_reg bytes, i_epoch_in
//  result    o_valid (strobe)    o_epoch_out, o_clock_valid, o_*_bcd,
//                                o_weekday, o_range_error
//
//  One word accepted per cycle; busy stays low. A result strobes once its
//  command has passed the nine-stage epoch-to-BCD pipeline plus the output
//  register; the to-epoch path is padded to the same depth.
//  Results are shown for one cycle and the receiver cannot stall them.
//  Synchronous reset clears the valid bits; words in flight are dropped.
// ============================================================================
module rtc_bcd_epoch_converter_top
    import rbec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [7:0]  i_seconds_reg,
    input  logic [7:0]  i_minutes_reg,
    input  logic [7:0]  i_hours_reg,
    input  logic [7:0]  i_days_reg,
    input  logic [7:0]  i_months_reg,
    input  logic [7:0]  i_years_reg,
    input  logic [31:0] i_epoch_in,
    output logic        o_valid,
    output logic [31:0] o_epoch_out,
    output logic        o_clock_valid,
    output logic [6:0]  o_seconds_bcd,
    output logic [6:0]  o_minutes_bcd,
    output logic [5:0]  o_hours_bcd,
    output logic [5:0]  o_day_bcd,
    output logic [2:0]  o_weekday,
    output logic [4:0]  o_month_bcd,
    output logic [7:0]  o_year_bcd,
    output logic        o_range_error
);

    // Fully pipelined: never busy
    assign busy = 1'b0;

    // ---------------- command accept and steering --------------------------
    logic      w_take;
    t_rtc_regs w_regs;
    t_enc_res  w_enc;
    t_dec_res  w_dec;

    assign w_take = start & ~busy;

    assign w_regs.seconds_reg = i_seconds_reg;
    assign w_regs.minutes_reg = i_minutes_reg;
    assign w_regs.hours_reg   = i_hours_reg;
    assign w_regs.days_reg    = i_days_reg;
    assign w_regs.months_reg  = i_months_reg;
    assign w_regs.years_reg   = i_years_reg;

    rbec_enc u_enc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_take && (i_mode == MODE_TO_EPOCH)),
        .i_regs  (w_regs),
        .o_res   (w_enc)
    );

    rbec_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_take && (i_mode == MODE_TO_BCD)),
        .i_epoch (i_epoch_in),
        .o_res   (w_dec)
    );

    // ---------------- output register: merge both paths ------------------
    // Paths have equal depth, so at most one of them is valid per cycle.
    logic        r_valid;
    logic [31:0] r_epoch_out;
    logic        r_clock_valid;
    logic [6:0]  r_seconds_bcd;
    logic [6:0]  r_minutes_bcd;
    logic [5:0]  r_hours_bcd;
    logic [5:0]  r_day_bcd;
    logic [2:0]  r_weekday;
    logic [4:0]  r_month_bcd;
    logic [7:0]  r_year_bcd;
    logic        r_range_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_enc.valid | w_dec.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enc.valid) begin
            r_epoch_out   <= w_enc.epoch;
            r_clock_valid <= w_enc.clock_valid;
            r_seconds_bcd <= '0;
            r_minutes_bcd <= '0;
            r_hours_bcd   <= '0;
            r_day_bcd     <= '0;
            r_weekday     <= '0;
            r_month_bcd   <= '0;
            r_year_bcd    <= '0;
            r_range_error <= 1'b0;
        end else begin
            r_epoch_out   <= '0;
            r_clock_valid <= 1'b0;
            r_seconds_bcd <= w_dec.seconds_bcd;
            r_minutes_bcd <= w_dec.minutes_bcd;
            r_hours_bcd   <= w_dec.hours_bcd;
            r_day_bcd     <= w_dec.day_bcd;
            r_weekday     <= w_dec.weekday;
            r_month_bcd   <= w_dec.month_bcd;
            r_year_bcd    <= w_dec.year_bcd;
            r_range_error <= w_dec.range_error;
        end
    end

    assign o_valid       = r_valid;
    assign o_epoch_out   = r_epoch_out;
    assign o_clock_valid = r_clock_valid;
    assign o_seconds_bcd = r_seconds_bcd;
    assign o_minutes_bcd = r_minutes_bcd;
    assign o_hours_bcd   = r_hours_bcd;
    assign o_day_bcd     = r_day_bcd;
    assign o_weekday     = r_weekday;
    assign o_month_bcd   = r_month_bcd;
    assign o_year_bcd    = r_year_bcd;
    assign o_range_error = r_range_error;

endmodule

/* test/rtc_bcd_epoch_converter_top_tb.sv */
// ----------------------------------------------------------------------------
// rtc_bcd_epoch_converter_top_tb - RTC register / epoch converter testbench
//
// Drives conversion words in both directions through the start/busy port. A
// short table of corner words goes first, then randomized words: mostly
// well-formed dates and in-range epochs, plus raw noise. Each accepted word
// gets a hand-typed or a modelled prediction, and every strobed
// result is checked in order against the oldest pending prediction.
// ----------------------------------------------------------------------------
module rtc_bcd_epoch_converter_top_tb
    import rbec_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Calendar constants for the days-from-civil arithmetic
    localparam longint CIVIL_SHIFT  = 719468;
    localparam longint DAYS_PER_ERA = 146097;
    localparam longint YEAR_BASE    = 2000;
    localparam longint YEAR_LAST    = 2099;

    // Register masks
    localparam logic [7:0] MASK_7BIT = 8'h7F;
    localparam logic [7:0] MASK_6BIT = 8'h3F;
    localparam logic [7:0] MASK_5BIT = 8'h1F;

    // Anchor epochs
    localparam logic [31:0] EPOCH_Y2000 = 32'd946684800;
    localparam logic [31:0] EPOCH_Y2100 = 32'd4102444800;
    localparam logic [31:0] EPOCH_Y2025 = 32'd1735689600;

    localparam int unsigned RAND_WORDS   = 1850;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned MAX_REPORTS  = 10;

    // One command word
    typedef struct packed {
        logic        mode;
        logic [7:0]  seconds_reg;
        logic [7:0]  minutes_reg;
        logic [7:0]  hours_reg;
        logic [7:0]  days_reg;
        logic [7:0]  months_reg;
        logic [7:0]  years_reg;
        logic [31:0] epoch_in;
    } t_conv_cmd;

    // One result word
    typedef struct packed {
        logic [31:0] epoch_out;
        logic        clock_valid;
        logic [6:0]  seconds_bcd;
        logic [6:0]  minutes_bcd;
        logic [5:0]  hours_bcd;
        logic [5:0]  day_bcd;
        logic [2:0]  weekday;
        logic [4:0]  month_bcd;
        logic [7:0]  year_bcd;
        logic        range_error;
    } t_conv_res;

    // Corner word, with a hand-typed result where has_exp is set
    typedef struct packed {
        logic      has_exp;
        t_conv_cmd cmd;
        t_conv_res res;
    } t_corner_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_mode;
    logic [7:0]  i_seconds_reg;
    logic [7:0]  i_minutes_reg;
    logic [7:0]  i_hours_reg;
    logic [7:0]  i_days_reg;
    logic [7:0]  i_months_reg;
    logic [7:0]  i_years_reg;
    logic [31:0] i_epoch_in;
    logic        o_valid;
    logic [31:0] o_epoch_out;
    logic        o_clock_valid;
    logic [6:0]  o_seconds_bcd;
    logic [6:0]  o_minutes_bcd;
    logic [5:0]  o_hours_bcd;
    logic [5:0]  o_day_bcd;
    logic [2:0]  o_weekday;
    logic [4:0]  o_month_bcd;
    logic [7:0]  o_year_bcd;
    logic        o_range_error;

    t_conv_res   pending_conversions[$];
    t_corner_row corner_rows[$];
    int unsigned mismatch_cnt;

    rtc_bcd_epoch_converter_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_seconds_reg (i_seconds_reg),
        .i_minutes_reg (i_minutes_reg),
        .i_hours_reg   (i_hours_reg),
        .i_days_reg    (i_days_reg),
        .i_months_reg  (i_months_reg),
        .i_years_reg   (i_years_reg),
        .i_epoch_in    (i_epoch_in),
        .o_valid       (o_valid),
        .o_epoch_out   (o_epoch_out),
        .o_clock_valid (o_clock_valid),
        .o_seconds_bcd (o_seconds_bcd),
        .o_minutes_bcd (o_minutes_bcd),
        .o_hours_bcd   (o_hours_bcd),
        .o_day_bcd     (o_day_bcd),
        .o_weekday     (o_weekday),
        .o_month_bcd   (o_month_bcd),
        .o_year_bcd    (o_year_bcd),
        .o_range_error (o_range_error)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on run time
    initial begin
        #5ms;
        $display("rtc_bcd_epoch_converter_top test failed");
        $finish;
    end

    // Binary below 100 to two BCD digits
    function automatic logic [7:0] bin2bcd(input longint unsigned v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    // Two nibbles weighted as tens and ones, no digit check
    function automatic longint nibble_weight(input logic [7:0] b);
        return longint'(b[7:4]) * 10 + longint'(b[3:0]);
    endfunction

    // Behavioral model of one conversion
    function automatic t_conv_res predict_conversion(input t_conv_cmd w);
        longint            sec, mins, hrs, mday, mon, yrs, yfull;
        longint            era, yoe, doy, doe, days, total;
        longint unsigned   ndays, tod, z, uera, udoe, uyoe, udoy, mp, cd, cm, cy;
        t_conv_res         r;
        r = '0;
        if (w.mode == MODE_TO_EPOCH) begin
            sec  = nibble_weight(w.seconds_reg & MASK_7BIT);
            mins = nibble_weight(w.minutes_reg & MASK_7BIT);
            hrs  = nibble_weight(w.hours_reg & MASK_6BIT);
            mday = nibble_weight(w.days_reg & MASK_6BIT);
            mon  = nibble_weight(w.months_reg & MASK_5BIT);
            yrs  = nibble_weight(w.years_reg);
            // days from civil, year shifted so that March starts it
            yfull = YEAR_BASE + yrs;
            if (mon <= 2)
                yfull = yfull - 1;
            era   = yfull / 400;
            yoe   = yfull - era * 400;
            doy   = (153 * (mon > 2 ? mon - 3 : mon + 9) + 2) / 5 + mday - 1;
            doe   = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days  = era * DAYS_PER_ERA + doe - CIVIL_SHIFT;
            total = days * SECS_PER_DAY + hrs * SECS_PER_HOUR + mins * SECS_PER_MIN + sec;
            r.epoch_out   = total[31:0];
            r.clock_valid = (w.seconds_reg[7] == 1'b0) && (yrs >= YEAR_MIN_OK);
        end else begin
            ndays = w.epoch_in / SECS_PER_DAY;
            tod   = w.epoch_in % SECS_PER_DAY;
            // civil from days
            z    = ndays + CIVIL_SHIFT;
            uera = z / DAYS_PER_ERA;
            udoe = z - uera * DAYS_PER_ERA;
            uyoe = (udoe - udoe / 1460 + udoe / 36524 - udoe / 146096) / 365;
            udoy = udoe - (365 * uyoe + uyoe / 4 - uyoe / 100);
            mp   = (5 * udoy + 2) / 153;
            cd   = udoy - (153 * mp + 2) / 5 + 1;
            cm   = (mp < 10) ? mp + 3 : mp - 9;
            cy   = uyoe + uera * 400 + ((cm <= 2) ? 1 : 0);
            if (cy < YEAR_BASE || cy > YEAR_LAST) begin
                r.range_error = 1'b1;
            end else begin
                r.seconds_bcd = 7'(bin2bcd(tod % 60));
                r.minutes_bcd = 7'(bin2bcd((tod / 60) % 60));
                r.hours_bcd   = 6'(bin2bcd(tod / 3600));
                r.day_bcd     = 6'(bin2bcd(cd));
                r.weekday     = 3'((ndays + WEEKDAY_OFS) % 7);
                r.month_bcd   = 5'(bin2bcd(cm));
                r.year_bcd    = bin2bcd(cy - YEAR_BASE);
            end
        end
        return r;
    endfunction

    function automatic t_conv_cmd make_cmd(input logic mode, input logic [7:0] s,
                                           input logic [7:0] mi, input logic [7:0] h,
                                           input logic [7:0] d, input logic [7:0] mo,
                                           input logic [7:0] y, input logic [31:0] e);
        t_conv_cmd w;
        w = '{mode, s, mi, h, d, mo, y, e};
        return w;
    endfunction

    function automatic t_conv_res epoch_result(input logic [31:0] e, input logic cv);
        t_conv_res r;
        r = '0;
        r.epoch_out   = e;
        r.clock_valid = cv;
        return r;
    endfunction

    function automatic t_conv_res bcd_result(input logic [6:0] s, input logic [6:0] mi,
                                             input logic [5:0] h, input logic [5:0] d,
                                             input logic [2:0] wd, input logic [4:0] mo,
                                             input logic [7:0] y);
        t_conv_res r;
        r = '0;
        r.seconds_bcd = s;
        r.minutes_bcd = mi;
        r.hours_bcd   = h;
        r.day_bcd     = d;
        r.weekday     = wd;
        r.month_bcd   = mo;
        r.year_bcd    = y;
        return r;
    endfunction

    function automatic t_conv_res range_result();
        t_conv_res r;
        r = '0;
        r.range_error = 1'b1;
        return r;
    endfunction

    // Random word: mostly well-formed content, the rest raw noise
    function automatic t_conv_cmd random_command();
        t_conv_cmd   w;
        int unsigned kind;
        w = make_cmd(1'($urandom_range(1, 0)), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom), $urandom);
        kind = $urandom_range(99, 0);
        if (w.mode == MODE_TO_EPOCH) begin
            if (kind < 80) begin
                // legal BCD in the live bits, junk left in the masked bits
                w.seconds_reg = {w.seconds_reg[7], 7'(bin2bcd($urandom_range(59, 0)))};
                w.minutes_reg = {w.minutes_reg[7], 7'(bin2bcd($urandom_range(59, 0)))};
                w.hours_reg   = {w.hours_reg[7:6], 6'(bin2bcd($urandom_range(23, 0)))};
                w.days_reg    = {w.days_reg[7:6], 6'(bin2bcd($urandom_range(31, 1)))};
                w.months_reg  = {w.months_reg[7:5], 5'(bin2bcd($urandom_range(12, 1)))};
                w.years_reg   = bin2bcd($urandom_range(99, 0));
            end
        end else begin
            if (kind < 70)
                w.epoch_in = $urandom_range(EPOCH_Y2100 - 1, EPOCH_Y2000);
            else if (kind < 85)
                w.epoch_in = (kind[0] ? EPOCH_Y2000 : EPOCH_Y2100) - 32'd100000
                             + 32'($urandom_range(200000, 0));
        end
        return w;
    endfunction

    // Idle gap before a word: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned k;
        k = $urandom_range(99, 0);
        if (k < 55)
            return 0;
        if (k < 88)
            return $urandom_range(3, 1);
        if (k < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Present one word after an optional gap, hold it until accepted
    task automatic issue_word(input t_conv_cmd w, input t_conv_res res, input int unsigned gap);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_mode        <= w.mode;
        i_seconds_reg <= w.seconds_reg;
        i_minutes_reg <= w.minutes_reg;
        i_hours_reg   <= w.hours_reg;
        i_days_reg    <= w.days_reg;
        i_months_reg  <= w.months_reg;
        i_years_reg   <= w.years_reg;
        i_epoch_in    <= w.epoch_in;
        do @(posedge i_clk); while (busy);
        pending_conversions.push_back(res);
    endtask

    // Hold off the sender until every pending result has come back
    task automatic drain_conversions();
        start <= 1'b0;
        while (pending_conversions.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Result checker: every strobe pops the oldest prediction
    always @(posedge i_clk) begin
        t_conv_res act;
        t_conv_res want;
        act = '{o_epoch_out, o_clock_valid, o_seconds_bcd, o_minutes_bcd, o_hours_bcd,
                o_day_bcd, o_weekday, o_month_bcd, o_year_bcd, o_range_error};
        if (i_rst_n && o_valid) begin
            if (pending_conversions.size() == 0) begin
                if (mismatch_cnt < MAX_REPORTS)
                    $display("%0t: result word with nothing pending: epoch %0d", $realtime,
                             act.epoch_out);
                mismatch_cnt = mismatch_cnt + 1;
            end else begin
                want = pending_conversions.pop_front();
                if (act !== want) begin
                    if (mismatch_cnt < MAX_REPORTS) begin
                        $display("%0t: mismatch", $realtime);
                        $display("  exp epoch %0d cv %b s %h m %h h %h d %h wd %0d mo %h y %h re %b",
                                 want.epoch_out, want.clock_valid, want.seconds_bcd,
                                 want.minutes_bcd, want.hours_bcd, want.day_bcd, want.weekday,
                                 want.month_bcd, want.year_bcd, want.range_error);
                        $display("  act epoch %0d cv %b s %h m %h h %h d %h wd %0d mo %h y %h re %b",
                                 act.epoch_out, act.clock_valid, act.seconds_bcd,
                                 act.minutes_bcd, act.hours_bcd, act.day_bcd, act.weekday,
                                 act.month_bcd, act.year_bcd, act.range_error);
                    end
                    mismatch_cnt = mismatch_cnt + 1;
                end
            end
        end
    end

    // Main sequence
    initial begin
        t_conv_cmd cmd;
        t_conv_res res;

        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_mode        = MODE_TO_EPOCH;
        i_seconds_reg = '0;
        i_minutes_reg = '0;
        i_hours_reg   = '0;
        i_days_reg    = '0;
        i_months_reg  = '0;
        i_years_reg   = '0;
        i_epoch_in    = '0;
        mismatch_cnt  = 0;

        // Corner words; register bytes to epoch first
        // all-zero bytes land on month 0, day 0 of 1999, i.e. Nov 30 1999
        corner_rows.push_back(t_corner_row'{1'b1,
            make_cmd(MODE_TO_EPOCH, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0),
            epoch_result(32'd943920000, 1'b0)});
        corner_rows.push_back(t_corner_row'{1'b1,
            make_cmd(MODE_TO_EPOCH, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 32'd0),
            epoch_result(EPOCH_Y2000, 1'b0)});
        corner_rows.push_back(t_corner_row'{1'b1,
            make_cmd(MODE_TO_EPOCH, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 32'hFFFF_FFFF),
            epoch_result(EPOCH_Y2100 - 32'd1, 1'b1)});
        // oscillator stopped: same epoch, clock not trusted
        corner_rows.push_back(t_corner_row'{1'b1,
            make_cmd(MODE_TO_EPOCH, 8'hD9, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 32'd0),
            epoch_result(EPOCH_Y2100 - 32'd1, 1'b0)});
        // first year the clock counts as set
        corner_rows.push_back(t_corner_row'{1'b1,
            make_cmd(MODE_TO_EPOCH, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h25, 32'd0),
            epoch_result(EPOCH_Y2025, 1'b1)});
        corner_rows.push_back(t_corner_row'{1'b0,
            make_cmd(MODE_TO_EPOCH, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h24, 32'd0), '0});
        // all ones: non-BCD digits everywhere, year past 2099
        corner_rows.push_back(t_corner_row'{1'b0,
            make_cmd(MODE_TO_EPOCH, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF), '0});
        corner_rows.push_back(t_corner_row'{1'b0,
            make_cmd(MODE_TO_EPOCH, 8'h7F, 8'h7F, 8'h3F, 8'h3F, 8'h1F, 8'h9A, 32'd0), '0});
        // month 0, month above 12, day 0 at the start of the March year
        corner_rows.push_back(t_corner_row'{1'b0,
            make_cmd(MODE_TO_EPOCH, 8'h30, 8'h15, 8'h10, 8'h15, 8'h00, 8'h50, 32'd0), '0});
        corner_rows.push_back(t_corner_row'{1'b0,
            make_cmd(MODE_TO_EPOCH, 8'h30, 8'h15, 8'h10, 8'h15, 8'h13, 8'h50, 32'd0), '0});
        corner_rows.push_back(t_corner_row'{1'b0,
            make_cmd(MODE_TO_EPOCH, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 32'd0), '0});
        // leap day, then masked high bits set on a legal time
        corner_rows.push_back(t_corner_row'{1'b0,
            make_cmd(MODE_TO_EPOCH, 8'h56, 8'h34, 8'h12, 8'h29, 8'h02, 8'h24, 32'd0), '0});
        corner_rows.push_back(t_corner_row'{1'b0,
            make_cmd(MODE_TO_EPOCH, 8'h45, 8'hC5, 8'hD2, 8'hC7, 8'hE6, 8'h31, 32'd0), '0});

        // Epoch to register bytes
        corner_rows.push_back(t_corner_row'{1'b1,
            make_cmd(MODE_TO_BCD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0),
            range_result()});
        corner_rows.push_back(t_corner_row'{1'b1,
            make_cmd(MODE_TO_BCD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF),
            range_result()});
        corner_rows.push_back(t_corner_row'{1'b1,
            make_cmd(MODE_TO_BCD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, EPOCH_Y2000 - 32'd1),
            range_result()});
        // Jan 1 2000 was a Saturday
        corner_rows.push_back(t_corner_row'{1'b1,
            make_cmd(MODE_TO_BCD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, EPOCH_Y2000),
            bcd_result(7'h00, 7'h00, 6'h00, 6'h01, 3'd6, 5'h01, 8'h00)});
        // Dec 31 2099 is a Thursday
        corner_rows.push_back(t_corner_row'{1'b1,
            make_cmd(MODE_TO_BCD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, EPOCH_Y2100 - 32'd1),
            bcd_result(7'h59, 7'h59, 6'h23, 6'h31, 3'd4, 5'h12, 8'h99)});
        corner_rows.push_back(t_corner_row'{1'b1,
            make_cmd(MODE_TO_BCD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, EPOCH_Y2100),
            range_result()});
        corner_rows.push_back(t_corner_row'{1'b0,
            make_cmd(MODE_TO_BCD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd951782399), '0});
        corner_rows.push_back(t_corner_row'{1'b0,
            make_cmd(MODE_TO_BCD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd951782400), '0});
        corner_rows.push_back(t_corner_row'{1'b0,
            make_cmd(MODE_TO_BCD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd1709164800), '0});
        corner_rows.push_back(t_corner_row'{1'b0,
            make_cmd(MODE_TO_BCD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, EPOCH_Y2025 - 32'd1),
            '0});
        // register bytes are don't-care in this direction
        corner_rows.push_back(t_corner_row'{1'b0,
            make_cmd(MODE_TO_BCD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'd1234567890), '0});

        // Reset
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corner table
        foreach (corner_rows[i]) begin
            res = corner_rows[i].has_exp ? corner_rows[i].res
                                         : predict_conversion(corner_rows[i].cmd);
            issue_word(corner_rows[i].cmd, res, pick_gap());
        end
        drain_conversions();

        // Random words, with one full drain midway
        for (int unsigned n = 0; n < RAND_WORDS; n++) begin
            if (n == RAND_WORDS / 2)
                drain_conversions();
            cmd = random_command();
            issue_word(cmd, predict_conversion(cmd), pick_gap());
        end
        start <= 1'b0;

        // Wait out the pipeline
        while (pending_conversions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_conversions.size() == 0) begin
            $display("rtc_bcd_epoch_converter_top test passed");
        end else begin
            $display("rtc_bcd_epoch_converter_top test failed");
        end
        $finish;
    end

endmodule
